@@ sv/rvrs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvrs_pkg: shared types for the range value remap store
// Command codes, sequencer states and the input and result transaction types.
// ----------------------------------------------------------------------------
package rvrs_pkg;

    localparam int VAL_W = 7;
    localparam int IDX_W = 12;
    localparam int CNT_W = 13;
    localparam logic [CNT_W-1:0] COUNT_RESET = 13'd4096;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_REMAP = 2'd1,
        CMD_READ  = 2'd2,
        CMD_BAD   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_WRITE = 2'd0,
        ST_MID   = 2'd1,
        ST_LAST  = 2'd2,
        ST_NONE  = 2'd3
    } t_step;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_L,
        S_FIND_R,
        S_TBL_RD,
        S_TBL_WR,
        S_SET_START,
        S_SET_E,
        S_SET_T,
        S_SET_W,
        S_POST,
        S_PART_R,
        S_PART_W,
        S_WR,
        S_RD_E,
        S_RD_T,
        S_RD_D
    } t_state;

    typedef struct packed {
        logic [1:0]       command;
        logic [IDX_W-1:0] left_index;
        logic [IDX_W-1:0] right_index;
        logic [VAL_W-1:0] from_value;
        logic [VAL_W-1:0] to_value;
        logic [VAL_W-1:0] write_value;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic             error;
    } t_out_item;

endpackage

@@ sv/range_value_remap_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_value_remap_store: block-decomposed array with lazy value remapping
// Element store plus one pending remap table per block, walked by a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a command transaction on i_in while busy is low; it is
//   taken at that edge and busy stays high until the result is shown. The
//   result sits on o_out for exactly one cycle with o_done high; the receiver
//   must take it then, it cannot stall the block.
//   Write element_count on the cfg channel (always ready) only while idle.
// Sequence of work:
//   locating a block walks one block per cycle;
//   a pending table is folded into its block by reading each element,
//   looking it up in the table and writing it back; a partial range edit
//   reads each element and rewrites it if it matches; a covered block's
//   table has each value entry read and then rewritten.
//   A new command can be taken in the cycle after the result strobe.
// Reset: all tables read as identity at once (one clean bit per block, no
//   clearing pass), element_count returns to 4096, elements stay undefined.
// Rejected commands skip all work and go straight to showing their result.
// ----------------------------------------------------------------------------
module range_value_remap_store #(
    parameter int ARRAY_SIZE = 4096,
    parameter int BLOCK_SIZE = 64,
    parameter int MAX_VALUE  = 100
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  rvrs_pkg::t_in_item          i_in,
    output rvrs_pkg::t_out_item         o_out,
    output logic                        o_done,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rvrs_pkg::CNT_W-1:0]  i_cfg_data
);

    import rvrs_pkg::*;

    localparam int NUM_BLOCKS = (ARRAY_SIZE + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int EW = $clog2(ARRAY_SIZE);
    localparam int BW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int TW = BW + VAL_W;
    localparam logic [VAL_W-1:0] MAXV = VAL_W'(MAX_VALUE);

    t_state            r_state, n_state;
    t_in_item          r_in;
    logic              r_err, n_err;
    logic [VAL_W-1:0]  r_rv, n_rv;
    logic [CNT_W-1:0]  r_count;
    logic [BW-1:0]     r_blk, n_blk, r_bl, n_bl, r_br, n_br, r_cb, n_cb;
    logic [EW-1:0]     r_base, n_base, r_bl_base, n_bl_base, r_br_base, n_br_base;
    logic [EW-1:0]     r_cbase, n_cbase, r_ptr, n_ptr, r_end, n_end;
    logic [EW-1:0]     r_plo, n_plo, r_phi, n_phi;
    logic [VAL_W-1:0]  r_v, n_v;
    t_step             r_step, n_step;
    logic [NUM_BLOCKS-1:0] r_dirty;
    logic              dirty_set, dirty_clr;
    // S_RD_D is entered once to settle the result, then held while the strobe
    // is shown
    logic              r_done_q;

    logic              e_we, e_re, t_we, t_re;
    logic [EW-1:0]     e_waddr, e_raddr;
    logic [VAL_W-1:0]  e_wdata, e_q, t_wdata, t_q;
    logic [TW-1:0]     t_waddr, t_raddr;

    logic              in_err;
    logic              step_more_l, step_more_r;
    logic              cur_dirty, eq_in_range;
    logic [VAL_W-1:0]  tbl_cur;
    logic [31:0]       set_end;

    function automatic logic idx_ok(input logic [IDX_W-1:0] i, input logic [CNT_W-1:0] c);
        return (32'(i) < 32'(c)) && (32'(i) < 32'(ARRAY_SIZE));
    endfunction

    function automatic logic val_ok(input logic [VAL_W-1:0] v);
        return (v != '0) && (v <= MAXV);
    endfunction

    // Validate the incoming command against the current element count
    always_comb begin
        unique case (t_cmd'(i_in.command))
            CMD_WRITE: in_err = !idx_ok(i_in.left_index, r_count) || !val_ok(i_in.write_value);
            CMD_REMAP: in_err = !idx_ok(i_in.left_index, r_count)
                             || !idx_ok(i_in.right_index, r_count)
                             || (i_in.left_index > i_in.right_index)
                             || !val_ok(i_in.from_value) || !val_ok(i_in.to_value);
            CMD_READ:  in_err = !idx_ok(i_in.left_index, r_count);
            default:   in_err = 1'b1;
        endcase
    end

    assign step_more_l = (32'(r_base) + 32'(BLOCK_SIZE)) <= 32'(r_in.left_index);
    assign step_more_r = (32'(r_base) + 32'(BLOCK_SIZE)) <= 32'(r_in.right_index);
    assign cur_dirty   = r_dirty[r_cb];
    assign eq_in_range = val_ok(e_q);
    assign tbl_cur     = cur_dirty ? t_q : r_v;
    assign set_end     = ((32'(r_cbase) + 32'(BLOCK_SIZE)) > 32'(ARRAY_SIZE))
                       ? 32'(ARRAY_SIZE) - 32'd1
                       : 32'(r_cbase) + 32'(BLOCK_SIZE) - 32'd1;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = in_err ? S_RD_D : S_FIND_L;
                end
            end
            S_FIND_L: begin
                if (!step_more_l) begin
                    unique case (t_cmd'(r_in.command))
                        CMD_REMAP: n_state = S_FIND_R;
                        CMD_WRITE: n_state = S_SET_START;
                        default:   n_state = S_RD_E;
                    endcase
                end
            end
            S_FIND_R: begin
                if (!step_more_r) begin
                    if (r_blk == r_bl || r_blk == r_bl + BW'(1)) begin
                        n_state = S_SET_START;
                    end else begin
                        n_state = S_TBL_RD;
                    end
                end
            end
            S_TBL_RD: n_state = S_TBL_WR;
            S_TBL_WR: begin
                if (r_v == MAXV && r_cb + BW'(1) == r_br) begin
                    n_state = S_SET_START;
                end else begin
                    n_state = S_TBL_RD;
                end
            end
            S_SET_START: n_state = cur_dirty ? S_SET_E : S_POST;
            S_SET_E:     n_state = S_SET_T;
            S_SET_T:     n_state = S_SET_W;
            S_SET_W:     n_state = (r_ptr == r_end) ? S_POST : S_SET_E;
            S_POST:      n_state = (r_step == ST_WRITE) ? S_WR : S_PART_R;
            S_PART_R:    n_state = S_PART_W;
            S_PART_W: begin
                if (r_ptr == r_phi) begin
                    n_state = (r_step == ST_MID) ? S_SET_START : S_RD_D;
                end else begin
                    n_state = S_PART_R;
                end
            end
            S_WR:   n_state = S_RD_D;
            S_RD_E: n_state = S_RD_T;
            S_RD_T: n_state = S_RD_D;
            S_RD_D: n_state = r_done_q ? S_IDLE : S_RD_D;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_err     = r_err;
        n_rv      = r_rv;
        n_blk     = r_blk;
        n_base    = r_base;
        n_bl      = r_bl;
        n_bl_base = r_bl_base;
        n_br      = r_br;
        n_br_base = r_br_base;
        n_cb      = r_cb;
        n_cbase   = r_cbase;
        n_ptr     = r_ptr;
        n_end     = r_end;
        n_plo     = r_plo;
        n_phi     = r_phi;
        n_v       = r_v;
        n_step    = r_step;
        dirty_set = 1'b0;
        dirty_clr = 1'b0;
        e_we      = 1'b0;
        e_re      = 1'b0;
        e_waddr   = r_ptr;
        e_raddr   = r_ptr;
        e_wdata   = e_q;
        t_we      = 1'b0;
        t_re      = 1'b0;
        t_waddr   = {r_cb, r_v};
        t_raddr   = {r_cb, r_v};
        t_wdata   = tbl_cur;
        unique case (r_state)
            S_IDLE: begin
                n_err  = in_err;
                n_rv   = '0;
                n_blk  = '0;
                n_base = '0;
            end
            S_FIND_L: begin
                if (step_more_l) begin
                    n_blk  = r_blk + BW'(1);
                    n_base = r_base + EW'(BLOCK_SIZE);
                end else begin
                    n_bl      = r_blk;
                    n_bl_base = r_base;
                    n_cb      = r_blk;
                    n_cbase   = r_base;
                    n_step    = ST_WRITE;
                end
            end
            S_FIND_R: begin
                if (step_more_r) begin
                    n_blk  = r_blk + BW'(1);
                    n_base = r_base + EW'(BLOCK_SIZE);
                end else begin
                    n_br      = r_blk;
                    n_br_base = r_base;
                    if (r_blk == r_bl) begin
                        // Whole range inside one block
                        n_plo  = EW'(r_in.left_index);
                        n_phi  = EW'(r_in.right_index);
                        n_step = ST_LAST;
                    end else if (r_blk == r_bl + BW'(1)) begin
                        n_plo  = EW'(r_in.left_index);
                        n_phi  = r_base - EW'(1);
                        n_step = ST_MID;
                    end else begin
                        n_cb   = r_bl + BW'(1);
                        n_v    = VAL_W'(1);
                        n_step = ST_MID;
                    end
                end
            end
            S_TBL_RD: begin
                t_re = 1'b1;
            end
            S_TBL_WR: begin
                // Rewrite one table entry; a clean table reads as identity
                t_we    = 1'b1;
                t_wdata = (tbl_cur == r_in.from_value) ? r_in.to_value : tbl_cur;
                if (r_v == MAXV) begin
                    dirty_set = 1'b1;
                    n_v       = VAL_W'(1);
                    if (r_cb + BW'(1) == r_br) begin
                        n_cb    = r_bl;
                        n_cbase = r_bl_base;
                        n_plo   = EW'(r_in.left_index);
                        n_phi   = r_br_base - EW'(1);
                    end else begin
                        n_cb = r_cb + BW'(1);
                    end
                end else begin
                    n_v = r_v + VAL_W'(1);
                end
            end
            S_SET_START: begin
                n_ptr = r_cbase;
                n_end = EW'(set_end);
            end
            S_SET_E: begin
                e_re = 1'b1;
            end
            S_SET_T: begin
                t_re    = 1'b1;
                t_raddr = {r_cb, e_q};
            end
            S_SET_W: begin
                e_we    = 1'b1;
                e_wdata = eq_in_range ? t_q : e_q;
                if (r_ptr == r_end) begin
                    dirty_clr = 1'b1;
                end else begin
                    n_ptr = r_ptr + EW'(1);
                end
            end
            S_POST: begin
                n_ptr = r_plo;
            end
            S_PART_R: begin
                e_re = 1'b1;
            end
            S_PART_W: begin
                e_we    = (e_q == r_in.from_value);
                e_wdata = r_in.to_value;
                if (r_ptr == r_phi) begin
                    if (r_step == ST_MID) begin
                        n_cb    = r_br;
                        n_cbase = r_br_base;
                        n_plo   = r_br_base;
                        n_phi   = EW'(r_in.right_index);
                        n_step  = ST_LAST;
                    end
                end else begin
                    n_ptr = r_ptr + EW'(1);
                end
            end
            S_WR: begin
                e_we    = 1'b1;
                e_waddr = EW'(r_in.left_index);
                e_wdata = r_in.write_value;
            end
            S_RD_E: begin
                e_re    = 1'b1;
                e_raddr = EW'(r_in.left_index);
            end
            S_RD_T: begin
                t_re    = 1'b1;
                t_raddr = {r_bl, e_q};
            end
            S_RD_D: begin
                if (!r_done_q && !r_err && t_cmd'(r_in.command) == CMD_READ) begin
                    n_rv = (r_dirty[r_bl] && eq_in_range) ? t_q : e_q;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= COUNT_RESET;
            r_dirty  <= '0;
            r_done_q <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_done_q <= (r_state == S_RD_D) && !r_done_q;
            if (i_cfg_valid) begin
                r_count <= i_cfg_data;
            end
            if (dirty_set) begin
                r_dirty[r_cb] <= 1'b1;
            end else if (dirty_clr) begin
                r_dirty[r_cb] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_in <= i_in;
        end
        r_err     <= n_err;
        r_rv      <= n_rv;
        r_blk     <= n_blk;
        r_base    <= n_base;
        r_bl      <= n_bl;
        r_bl_base <= n_bl_base;
        r_br      <= n_br;
        r_br_base <= n_br_base;
        r_cb      <= n_cb;
        r_cbase   <= n_cbase;
        r_ptr     <= n_ptr;
        r_end     <= n_end;
        r_plo     <= n_plo;
        r_phi     <= n_phi;
        r_v       <= n_v;
        r_step    <= n_step;
    end

    rvrs_ram #(.WIDTH(VAL_W), .DEPTH(1 << EW)) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_re    (e_re),
        .i_raddr (e_raddr),
        .o_rdata (e_q)
    );

    rvrs_ram #(.WIDTH(VAL_W), .DEPTH(1 << TW)) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_re    (t_re),
        .i_raddr (t_raddr),
        .o_rdata (t_q)
    );

    // Outputs
    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done_q;
    assign o_out.read_value = r_rv;
    assign o_out.error      = r_err;
    assign o_cfg_ready      = 1'b1;

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");
    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("block still busy after result");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out.error) |-> (o_out.read_value == '0))
        else $error("rejected command returned a value");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

endmodule

@@ sv/rvrs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvrs_ram: generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module rvrs_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
